// File: hw/rtl/fmss_pkg.sv
// ----------------------------------------------------------------------------
// fmss_pkg: shared types and constants
// Widths, limits, controller states and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package fmss_pkg;

   // Field and register widths
   localparam int INDEX_W = 63;
   localparam int RES_W   = 10;
   localparam int MOD_W   = 11;
   localparam int COUNT_W = 13;
   localparam int PROD_W  = 2 * RES_W;

   // Modulus limits
   localparam int MOD_MAX   = 1024;
   localparam int MOD_RESET = 10;

   // Divider: one quotient bit per cycle over the full dividend
   localparam int DIV_STEPS = INDEX_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIVIDE_INDEX,
      ST_WALK,
      ST_MULTIPLY,
      ST_DIVIDE_PRODUCT,
      ST_FINISH
   } fmss_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_index;
      logic init_pair;
      logic step;
      logic start_index_div;
      logic capture_remainder;
      logic multiply;
      logic start_product_div;
      logic load_result;
   } fmss_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic mod_small;
      logic search_end;
      logic walk_end;
      logic div_done;
      logic rsp_free;
   } fmss_status_type;

endpackage

// File: hw/rtl/fmss_divider.sv
// ----------------------------------------------------------------------------
// fmss_divider: restoring remainder unit
// Reduces a 63-bit dividend by a 13-bit divisor, one bit per cycle, and
// pulses done with the remainder ready.
// ----------------------------------------------------------------------------
module fmss_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fmss_pkg::INDEX_W-1:0]  dividend,
   input  logic [fmss_pkg::COUNT_W-1:0]  divisor,
   output logic                          done,
   output logic [fmss_pkg::COUNT_W-1:0]  remainder
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [fmss_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic [fmss_pkg::INDEX_W-1:0]   shift_ff, shift_in;
   logic [fmss_pkg::COUNT_W-1:0]   divisor_ff, divisor_in;
   logic [fmss_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [fmss_pkg::COUNT_W:0]     trial;

   // Shift one dividend bit into the partial remainder and subtract if it fits
   always_comb begin
      trial      = {rem_ff, shift_ff[fmss_pkg::INDEX_W-1]};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         shift_in   = dividend;
         divisor_in = divisor;
         rem_in     = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[fmss_pkg::INDEX_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = fmss_pkg::COUNT_W'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[fmss_pkg::COUNT_W-1:0];
         end
         count_in = count_ff + 1'b1;
         if (count_ff == fmss_pkg::DIV_CNT_W'(fmss_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   // A new division never cuts into one in flight
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   // The finished remainder lies below the divisor
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor_ff))
      else $error("remainder not below divisor");

endmodule

// File: hw/rtl/fmss_datapath.sv
// ----------------------------------------------------------------------------
// fmss_datapath: residue pair, counters, product and result register
// Holds the modulus register, steps the Fibonacci pair mod m, feeds the
// shared remainder unit and keeps the result beat until it is taken.
// ----------------------------------------------------------------------------
module fmss_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [fmss_pkg::MOD_W-1:0]    csr_modulus,
   input  logic [fmss_pkg::INDEX_W-1:0]  req_number_index,
   input  fmss_pkg::fmss_cmd_type        cmd,
   output fmss_pkg::fmss_status_type     status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [fmss_pkg::RES_W-1:0]    rsp_fib_residue,
   output logic [fmss_pkg::RES_W-1:0]    rsp_square_sum_residue
);

   logic [fmss_pkg::MOD_W-1:0]   modulus_ff, modulus_in;
   logic [fmss_pkg::INDEX_W-1:0] index_ff, index_in;
   logic [fmss_pkg::RES_W-1:0]   older_ff, older_in;
   logic [fmss_pkg::RES_W-1:0]   newer_ff, newer_in;
   logic [fmss_pkg::COUNT_W-1:0] step_count_ff, step_count_in;
   logic [fmss_pkg::COUNT_W-1:0] reduced_ff, reduced_in;
   logic [fmss_pkg::PROD_W-1:0]  product_ff, product_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fmss_pkg::RES_W-1:0]   fib_ff, fib_in;
   logic [fmss_pkg::RES_W-1:0]   square_ff, square_in;

   logic [fmss_pkg::MOD_W-1:0]   mod_eff;
   logic [fmss_pkg::COUNT_W-1:0] mod_wide;
   logic [fmss_pkg::COUNT_W-1:0] limit;
   logic [fmss_pkg::MOD_W-1:0]   pair_sum;
   logic [fmss_pkg::RES_W-1:0]   pair_next;

   logic                         div_start;
   logic [fmss_pkg::INDEX_W-1:0] div_dividend;
   logic [fmss_pkg::COUNT_W-1:0] div_divisor;
   logic                         div_done;
   logic [fmss_pkg::COUNT_W-1:0] div_rem;

   // Saturate the modulus and derive the period search limit of 6m
   always_comb begin
      if (modulus_ff > fmss_pkg::MOD_W'(fmss_pkg::MOD_MAX)) begin
         mod_eff = fmss_pkg::MOD_W'(fmss_pkg::MOD_MAX);
      end else begin
         mod_eff = modulus_ff;
      end
      mod_wide = fmss_pkg::COUNT_W'(mod_eff);
      limit    = (mod_wide << 2) + (mod_wide << 1);
   end

   // Next term: both terms lie below m, so one conditional subtract reduces
   always_comb begin
      pair_sum = fmss_pkg::MOD_W'(older_ff) + fmss_pkg::MOD_W'(newer_ff);
      if (pair_sum >= mod_eff) begin
         pair_next = fmss_pkg::RES_W'(pair_sum - mod_eff);
      end else begin
         pair_next = fmss_pkg::RES_W'(pair_sum);
      end
   end

   // Remainder unit serves both the index and the product reduction
   assign div_start    = cmd.start_index_div | cmd.start_product_div;
   assign div_dividend = cmd.start_index_div ? index_ff
                                             : fmss_pkg::INDEX_W'(product_ff);
   assign div_divisor  = cmd.start_index_div ? step_count_ff : mod_wide;

   fmss_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Register updates under command
   always_comb begin
      modulus_in    = modulus_ff;
      index_in      = index_ff;
      older_in      = older_ff;
      newer_in      = newer_ff;
      step_count_in = step_count_ff;
      reduced_in    = reduced_ff;
      product_in    = product_ff;
      rsp_valid_in  = rsp_valid_ff;
      fib_in        = fib_ff;
      square_in     = square_ff;

      if (csr_valid) begin
         modulus_in = csr_modulus;
      end
      if (cmd.load_index) begin
         index_in = req_number_index;
      end
      if (cmd.init_pair) begin
         older_in      = '0;
         newer_in      = fmss_pkg::RES_W'(1);
         step_count_in = '0;
      end else if (cmd.step) begin
         older_in      = newer_ff;
         newer_in      = pair_next;
         step_count_in = step_count_ff + 1'b1;
      end
      if (cmd.capture_remainder) begin
         reduced_in = div_rem;
      end
      if (cmd.multiply) begin
         product_in = fmss_pkg::PROD_W'(older_ff) * fmss_pkg::PROD_W'(newer_ff);
      end

      // Drop the result beat once taken, load a new one when commanded
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
         if (status.mod_small) begin
            fib_in    = '0;
            square_in = '0;
         end else begin
            fib_in    = older_ff;
            square_in = div_rem[fmss_pkg::RES_W-1:0];
         end
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= fmss_pkg::MOD_W'(fmss_pkg::MOD_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      index_ff      <= index_in;
      older_ff      <= older_in;
      newer_ff      <= newer_in;
      step_count_ff <= step_count_in;
      reduced_ff    <= reduced_in;
      product_ff    <= product_in;
      fib_ff        <= fib_in;
      square_ff     <= square_in;
   end

   // Status back to the controller
   always_comb begin
      status.mod_small  = (mod_eff < fmss_pkg::MOD_W'(2));
      status.search_end = ((older_ff == '0) && (newer_ff == fmss_pkg::RES_W'(1))
                           && (step_count_ff != '0)) || (step_count_ff >= limit);
      status.walk_end   = (step_count_ff == reduced_ff);
      status.div_done   = div_done;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_fib_residue        = fib_ff;
   assign rsp_square_sum_residue = square_ff;

   // A waiting result beat is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_valid_ff || rsp_ready))
      else $error("result beat overwritten");

endmodule

// File: hw/rtl/fmss_controller.sv
// ----------------------------------------------------------------------------
// fmss_controller: sequencing state machine
// Runs the period search, index reduction, remainder walk and product
// reduction for one item at a time.
// ----------------------------------------------------------------------------
module fmss_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fmss_pkg::fmss_status_type  status,
   output fmss_pkg::fmss_cmd_type     cmd
);

   fmss_pkg::fmss_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fmss_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_index = 1'b1;
               if (status.mod_small) begin
                  state_in = fmss_pkg::ST_FINISH;
               end else begin
                  cmd.init_pair = 1'b1;
                  state_in      = fmss_pkg::ST_SEARCH;
               end
            end
         end
         fmss_pkg::ST_SEARCH: begin
            if (status.search_end) begin
               cmd.start_index_div = 1'b1;
               state_in            = fmss_pkg::ST_DIVIDE_INDEX;
            end else begin
               cmd.step = 1'b1;
            end
         end
         fmss_pkg::ST_DIVIDE_INDEX: begin
            if (status.div_done) begin
               cmd.capture_remainder = 1'b1;
               cmd.init_pair         = 1'b1;
               state_in              = fmss_pkg::ST_WALK;
            end
         end
         fmss_pkg::ST_WALK: begin
            if (status.walk_end) begin
               cmd.multiply = 1'b1;
               state_in     = fmss_pkg::ST_MULTIPLY;
            end else begin
               cmd.step = 1'b1;
            end
         end
         fmss_pkg::ST_MULTIPLY: begin
            cmd.start_product_div = 1'b1;
            state_in              = fmss_pkg::ST_DIVIDE_PRODUCT;
         end
         fmss_pkg::ST_DIVIDE_PRODUCT: begin
            if (status.div_done) begin
               state_in = fmss_pkg::ST_FINISH;
            end
         end
         fmss_pkg::ST_FINISH: begin
            // Hold until the result register frees up
            if (status.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in        = fmss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fmss_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/fibonacci_mod_square_sum.sv
// ----------------------------------------------------------------------------
// fibonacci_mod_square_sum: Fibonacci residue and sum of squares mod m
// Top level: controller and datapath, modulus register on the csr_ port.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one index n per beat; rsp_ returns F(n) mod m and the sum
//   of F(k)^2 for k up to n, mod m, one beat per request, in order.
//   csr_ writes the 11-bit modulus (reset 10, values above 1024 saturate,
//   below 2 give zero results); csr_ready is always high. Write it only
//   while no request is in flight.
//   With p the Pisano period of m (at most 6m) and r = n mod p, the pair
//   stepper walks the period and then the remainder, one step a cycle, and
//   the shared one-bit-a-cycle remainder unit reduces n and then
//   F(r)*F(r+1). A modulus below 2 skips the search and both reductions;
//   its zero result is loaded as soon as the output register is free.
//   One item is worked on at a time; the next request is taken once the
//   result beat is in the output register, even while it waits there.
//   If the receiver stalls with a beat still held, the next finished item
//   waits in place until the register frees up.
//   Reset is synchronous, active high: it restores the modulus to 10, drops
//   any result beat and returns to idle.
// ----------------------------------------------------------------------------
module fibonacci_mod_square_sum (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fmss_pkg::MOD_W-1:0]    csr_modulus,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fmss_pkg::INDEX_W-1:0]  req_number_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fmss_pkg::RES_W-1:0]    rsp_fib_residue,
   output logic [fmss_pkg::RES_W-1:0]    rsp_square_sum_residue
);

   fmss_pkg::fmss_cmd_type    cmd;
   fmss_pkg::fmss_status_type status;

   // Configuration writes land at once
   assign csr_ready = 1'b1;

   fmss_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fmss_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_modulus            (csr_modulus),
      .req_number_index       (req_number_index),
      .cmd                    (cmd),
      .status                 (status),
      .rsp_ready              (rsp_ready),
      .rsp_valid              (rsp_valid),
      .rsp_fib_residue        (rsp_fib_residue),
      .rsp_square_sum_residue (rsp_square_sum_residue)
   );

endmodule
